/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the substring replace block.
// Depends on nothing; each macro builds one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/srs_pkg.sv */
// Package of the substring replace stream: widths, register indexes and the
// structs passed between the window cells, the emission row and the top level.
`default_nettype none

package srs_pkg;

	localparam int DATA_W          = 8;
	localparam int LEN_W           = 4;
	localparam int CAP_W           = 16;
	localparam int CFG_W           = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int MAX_RESULTS     = 8;
	localparam int RLEN_MAX        = 8;
	localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
	localparam int MAX_PATTERN_DEF = 8;
	localparam int COUNT_BITS_DEF  = 17;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd256;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY          = 3'd4;

	// What a window cell loads at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_SHIFT1 = 2'd1,
		CELL_SHIFTP = 2'd2,
		CELL_CLEAR  = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic     ins;
		cell_op_t op;
	} cell_ctl_t;

	// One burst of result bytes handed to the emission row.
	typedef struct packed {
		logic                                load;
		logic [MAX_RESULTS-1:0][DATA_W-1:0]  row;
		logic [CNT_W-1:0]                    cnt;
		logic                                term;
		logic                                ok;
	} emit_job_t;

endpackage

`default_nettype wire

/* rtl/srs_if.sv */
// Channel interfaces of the substring replace stream: character input,
// result output and configuration write. Depends on srs_pkg.
`default_nettype none

interface srs_in_if;
	import srs_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface srs_out_if;
	import srs_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] char_out;
	logic              last;
	logic              ok;

	modport source (output valid, output char_out, output last, output ok, input ready);
	modport sink   (input valid, input char_out, input last, input ok, output ready);
endinterface

interface srs_cfg_if;
	import srs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/srs_cell.sv */
// One window cell: holds a character, compares it with its pattern byte and
// shifts from its neighbors. Depends on srs_pkg.
`default_nettype none

module srs_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srs_pkg::cell_ctl_t           ctl,
	input  logic [srs_pkg::DATA_W-1:0]   char_in,
	input  logic [srs_pkg::DATA_W-1:0]   pat_byte,
	input  logic [srs_pkg::DATA_W-1:0]   next_byte,
	input  logic [srs_pkg::DATA_W-1:0]   far_byte,
	output logic [srs_pkg::DATA_W-1:0]   cur_byte,
	output logic                         eq
);
	import srs_pkg::*;

	logic [DATA_W-1:0] ch_q;
	logic [DATA_W-1:0] ch_d;

	// The incoming character takes part in this cycle's compare.
	assign cur_byte = ctl.ins ? char_in : ch_q;
	assign eq       = (cur_byte == pat_byte);

	always_comb begin
		case (ctl.op)
			CELL_HOLD:   ch_d = cur_byte;
			CELL_SHIFT1: ch_d = next_byte;
			CELL_SHIFTP: ch_d = far_byte;
			CELL_CLEAR:  ch_d = '0;
			default:     ch_d = ch_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else begin
			ch_q <= ch_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/srs_emit.sv */
// Emission row: a row of byte cells that drains one result per cycle into
// the output register unless result stalls. Depends on srs_pkg and srs_out_if.
`default_nettype none

module srs_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  srs_pkg::emit_job_t job,
	output logic               job_free,
	srs_out_if.source          result
);
	import srs_pkg::*;

	logic [MAX_RESULTS-1:0][DATA_W-1:0] row_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic                               term_q;
	logic                               ok_q;
	logic                               valid_q;
	logic [DATA_W-1:0]                  char_q;
	logic                               last_q;
	logic                               res_ok_q;
	logic                               out_free;
	logic                               pop;
	logic                               final_byte;

	assign out_free   = !valid_q || result.ready;
	assign pop        = (cnt_q != '0) && out_free;
	assign final_byte = (cnt_q == CNT_W'(1));
	assign job_free   = (cnt_q == '0) || (final_byte && pop);

	assign result.valid    = valid_q;
	assign result.char_out = char_q;
	assign result.last     = last_q;
	assign result.ok       = res_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (job.load) begin
				cnt_q <= job.cnt;
			end else if (pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Each cell hands its byte to the one below as the row drains.
	always_ff @(posedge clk) begin
		if (job.load) begin
			row_q  <= job.row;
			term_q <= job.term;
			ok_q   <= job.ok;
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				row_q[i] <= row_q[i+1];
			end
			row_q[MAX_RESULTS-1] <= '0;
		end
		if (pop) begin
			char_q   <= row_q[0];
			last_q   <= term_q && final_byte;
			res_ok_q <= term_q && final_byte && ok_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/substring_replace_stream.sv */
// Substring replace stream: find-and-replace-all over a NUL-terminated string.
// Depends on srs_pkg, the srs interfaces, srs_cell and srs_emit.
//
// The block takes one character per transaction on chars and rewrites the
// string so that every leftmost, non-overlapping occurrence of the configured
// pattern is replaced by the configured replacement; the rewritten bytes leave
// one per transaction on result, the zero terminator last with last = 1 and
// ok telling whether the whole rewrite fit into capacity (ok is 0 for an
// empty pattern, a zero capacity or an overflow, and always 0 when last is 0).
// The unresolved characters sit in a row of MAX_PATTERN window cells; the
// incoming character, the pattern compare and the shift of the row all happen
// in the cycle the transaction is accepted. The results of one character go
// into an emission row of eight byte cells that drains one byte per cycle,
// unless result stalls, through an output register; an item that yields zero
// results leaves the input ready, while an item that yields results (a
// replacement, or the flush of the window plus terminator at the end of a
// string) holds the input until its last byte moves to the output register.
// The first result reaches result through the emission row and the output
// register. Configuration is written on cfg, which is always ready, and
// must only be written while the block is idle. After reset the block is
// ready at once; no clearing pass is needed.
`default_nettype none

module substring_replace_stream #(
	parameter int MAX_PATTERN = srs_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = srs_pkg::COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srs_in_if.sink     chars,
	srs_out_if.source  result,
	srs_cfg_if.sink    cfg
);
	import srs_pkg::*;

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int CMP_W  = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
	localparam logic [LEN_W-1:0]      PLEN_LIMIT = LEN_W'(MAX_PATTERN);
	localparam logic [LEN_W-1:0]      RLEN_LIMIT = LEN_W'(RLEN_MAX);
	localparam logic [FILL_W-1:0]     FILL_FULL  = FILL_W'(MAX_PATTERN);

	// Configuration registers.
	logic [CFG_W-1:0] pat_bytes_q;
	logic [LEN_W-1:0] pat_len_q;
	logic [CFG_W-1:0] rep_bytes_q;
	logic [LEN_W-1:0] rep_len_q;
	logic [CAP_W-1:0] cap_q;

	// Run state: number of characters in the window and bytes emitted so far.
	logic [FILL_W-1:0]     fill_q;
	logic [COUNT_BITS-1:0] out_count_q;

	logic [LEN_W-1:0]  plen;
	logic [CNT_W-1:0]  rlen;
	logic              acc;
	logic              is_term;
	logic              push;
	logic [LEN_W-1:0]  fill_post;
	logic [LEN_W-1:0]  fill_next;
	logic              resolve;
	logic              match;
	cell_op_t          op;

	logic [DATA_W-1:0]      cur    [MAX_PATTERN];
	logic [DATA_W-1:0]      next_b [MAX_PATTERN];
	logic [DATA_W-1:0]      far_b  [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;
	cell_ctl_t              ctl    [MAX_PATTERN];

	logic [MAX_RESULTS-1:0][DATA_W-1:0] job_row;
	logic [CNT_W-1:0]                   job_cnt;
	logic [COUNT_BITS:0]                count_sum;
	logic [COUNT_BITS-1:0]              count_sat;
	logic                               ok_now;
	logic                               job_free;
	emit_job_t                          job;

	// ------------------------------------------------------------------
	// Configuration port. Writes to indexes beyond the register list are
	// dropped.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			pat_len_q   <= '0;
			rep_bytes_q <= '0;
			rep_len_q   <= '0;
			cap_q       <= CAPACITY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PATTERN_BYTES:     pat_bytes_q <= cfg.data;
				REG_PATTERN_LEN:       pat_len_q   <= cfg.data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES: rep_bytes_q <= cfg.data;
				REG_REPLACEMENT_LEN:   rep_len_q   <= cfg.data[LEN_W-1:0];
				REG_CAPACITY:          cap_q       <= cfg.data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Length registers above their limits are clamped.
	assign plen = (pat_len_q > PLEN_LIMIT) ? PLEN_LIMIT : pat_len_q;
	assign rlen = CNT_W'((rep_len_q > RLEN_LIMIT) ? RLEN_LIMIT : rep_len_q);

	// ------------------------------------------------------------------
	// Window control. A character that is not the terminator enters the
	// cell at the fill position; once the window holds as many characters
	// as the pattern, it either matches (the matched characters leave) or
	// the oldest character leaves. The terminator empties the window.
	// ------------------------------------------------------------------
	assign chars.ready = job_free;
	assign acc         = chars.valid && chars.ready;
	assign is_term     = (chars.char_in == '0);
	assign push        = acc && !is_term && (fill_q < FILL_FULL);
	assign fill_post   = LEN_W'(fill_q) + LEN_W'(push);
	assign resolve     = acc && !is_term && (fill_post >= plen);

	always_comb begin
		match = (plen != '0);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((LEN_W'(i) < plen) && !eq[i]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		if (!acc) begin
			op        = CELL_HOLD;
			fill_next = LEN_W'(fill_q);
		end else if (is_term) begin
			op        = CELL_CLEAR;
			fill_next = '0;
		end else if (resolve && match) begin
			op        = CELL_SHIFTP;
			fill_next = fill_post - plen;
		end else if (resolve) begin
			op        = CELL_SHIFT1;
			fill_next = fill_post - LEN_W'(1);
		end else begin
			op        = CELL_HOLD;
			fill_next = fill_post;
		end
	end

	// ------------------------------------------------------------------
	// The row of window cells. Each cell sees its right neighbor for a
	// one-character shift and the cell a pattern length away for a shift
	// after a match; positions past the end read as zero.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		assign ctl[i].ins = push && (fill_q == FILL_W'(i));
		assign ctl[i].op  = op;

		if (i + 1 < MAX_PATTERN) begin : g_next
			assign next_b[i] = cur[i+1];
		end else begin : g_edge
			assign next_b[i] = '0;
		end

		always_comb begin
			far_b[i] = '0;
			for (int k = 1; k < MAX_PATTERN - i; k++) begin
				if (plen == LEN_W'(k)) begin
					far_b[i] = cur[i+k];
				end
			end
		end

		srs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.char_in   (chars.char_in),
			.pat_byte  (pat_bytes_q[DATA_W*i +: DATA_W]),
			.next_byte (next_b[i]),
			.far_byte  (far_b[i]),
			.cur_byte  (cur[i]),
			.eq        (eq[i])
		);
	end

	// ------------------------------------------------------------------
	// Result burst for the accepted character. At the terminator the
	// window contents are flushed; the cells past the fill position hold
	// zero, so the terminator byte follows them without extra muxing.
	// ------------------------------------------------------------------
	always_comb begin
		job_row = '0;
		job_cnt = '0;
		if (is_term) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				job_row[j] = cur[j];
			end
			job_cnt = CNT_W'(fill_q) + CNT_W'(1);
		end else if (resolve && match) begin
			job_row = rep_bytes_q;
			job_cnt = rlen;
		end else if (resolve) begin
			job_row[0] = cur[0];
			job_cnt    = CNT_W'(1);
		end
	end

	// The emitted-byte count saturates; a saturated count means overflow.
	assign count_sum = {1'b0, out_count_q} + (COUNT_BITS + 1)'(job_cnt);
	assign count_sat = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
		: count_sum[COUNT_BITS-1:0];
	assign ok_now = (plen != '0) && (cap_q != '0)
		&& (CMP_W'(count_sat) <= CMP_W'(cap_q)) && (count_sat != COUNT_MAX);

	assign job = '{
		load: acc,
		row:  job_row,
		cnt:  job_cnt,
		term: is_term,
		ok:   ok_now
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_count_q <= '0;
		end else if (acc) begin
			fill_q      <= FILL_W'(fill_next);
			out_count_q <= is_term ? '0 : count_sat;
		end
	end

	srs_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.job_free (job_free),
		.result   (result)
	);

endmodule

`default_nettype wire

/* rtl/srs_check.sv */
// Port checker of the substring replace stream and its bind to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srs_check (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_out,
	input logic       last,
	input logic       ok
);

	`ASSERT_NEXT(a_valid_held, clk, arst_n, out_valid && !out_ready, out_valid, "result valid dropped while stalled")
	`ASSERT_NEXT(a_payload_held, clk, arst_n, out_valid && !out_ready, $stable(char_out) && $stable(last) && $stable(ok), "result payload changed while stalled")
	`ASSERT_SAME(a_ok_on_last, clk, arst_n, out_valid && ok, last, "ok set on a result that is not last")
	`ASSERT_SAME(a_last_is_nul, clk, arst_n, out_valid && last, char_out == 8'd0, "last result is not the terminator")

endmodule

bind substring_replace_stream srs_check u_srs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.char_out  (result.char_out),
	.last      (result.last),
	.ok        (result.ok)
);

`default_nettype wire
